// File: sv/sos_pkg.sv
// Shared types, constants, saturation and sign-extension helpers for the second-order system stepper.
`default_nettype none

package sos_pkg;

    // Fixed word widths of the Q format values
    localparam int WORD_W   = 32;
    localparam int PROD_W   = 65;   // signed 33 x signed 32 product
    localparam int SUM_W    = 67;   // room for product plus a word without overflow
    localparam int CFG_IDX_W = 3;   // one spare bit so out-of-range indexes are visible

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAT_FREQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_OUT = 3'd3;

    // Request kinds carried on tuser
    localparam logic REQ_DRIVE = 1'b0;
    localparam logic REQ_TIME  = 1'b1;

    // Datapath operations: multiply issue and write-back use the same codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_VEL,     // y'  += dt * y''
        OP_POS,     // y   += dt * y'
        OP_W2,      // wn * wn
        OP_KW2,     // k * w2
        OP_DRIVE,   // (k * w2) * u
        OP_ZW,      // zeta * wn
        OP_DAMP,    // 2 * (zeta * wn) * y'
        OP_SPRING,  // w2 * y
        OP_ACC      // combine drive, damping and spring terms
    } sos_op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    accept;    // request taken this cycle
        sos_op_t mul_op;    // operands to multiply this cycle
        sos_op_t wb_op;     // product to write back this cycle
        logic    out_load;  // load output register with y
    } sos_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic first_step;   // next time request restarts the simulation
        logic out_free;     // output register can take a result this cycle
    } sos_stat_t;

    // Saturate a wide signed value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:WORD_W-1];
        all_zero = ~(|v[SUM_W-1:WORD_W-1]);
        if (all_one || all_zero)
            sat_word = v[WORD_W-1:0];
        else if (v[SUM_W-1])
            sat_word = {1'b1, {(WORD_W-1){1'b0}}};
        else
            sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // Sign-extend a word to the sum width
    function automatic logic signed [SUM_W-1:0] ext_word(input logic signed [WORD_W-1:0] v);
        ext_word = {{(SUM_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// File: sv/sos_ctrl.sv
// Controller state machine that sequences the shared multiplier for one time step.
`default_nettype none

module sos_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic              s_axis_tuser,
    input  wire sos_pkg::sos_stat_t stat,
    output sos_pkg::sos_cmd_t      cmd
);
    import sos_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_OUT
    } state_t;

    state_t  state_reg, state_next;
    sos_op_t op_reg, op_next;
    logic    accept;

    // Operation that follows a finished write-back
    function automatic sos_op_t succ_op(input sos_op_t op);
        case (op)
            OP_VEL:    succ_op = OP_POS;
            OP_POS:    succ_op = OP_W2;
            OP_W2:     succ_op = OP_KW2;
            OP_KW2:    succ_op = OP_DRIVE;
            OP_DRIVE:  succ_op = OP_ZW;
            OP_ZW:     succ_op = OP_DAMP;
            OP_DAMP:   succ_op = OP_SPRING;
            OP_SPRING: succ_op = OP_ACC;
            default:   succ_op = OP_NONE;
        endcase
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cmd.accept   = accept;
        cmd.mul_op   = OP_NONE;
        cmd.wb_op    = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == REQ_TIME))
                begin
                    op_next    = stat.first_step ? OP_W2 : OP_VEL;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_op = op_reg;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.wb_op = op_reg;
                op_next   = succ_op(op_reg);
                if (op_reg == OP_ACC)
                    state_next = ST_OUT;
                else if (op_reg == OP_SPRING)
                    state_next = ST_WB;     // combine step needs no multiply
                else
                    state_next = ST_MUL;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and current operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/sos_datapath.sv
// Datapath: configuration and state registers, shared multiplier, write-back and output register.
`default_nettype none

module sos_datapath
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [sos_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sos_pkg::WORD_W-1:0]  cfg_data,
    input  wire logic [2*sos_pkg::WORD_W-1:0] s_axis_tdata,
    input  wire logic                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [sos_pkg::WORD_W-1:0]       m_axis_tdata,
    input  wire sos_pkg::sos_cmd_t           cmd,
    output sos_pkg::sos_stat_t               stat
);
    import sos_pkg::*;

    localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

    // Configuration
    logic signed [WORD_W-1:0] gain_reg, zeta_reg, wn_reg, y0_reg;
    // Simulation state
    logic                     first_reg;
    logic        [WORD_W-1:0] last_time_reg, dt_reg;
    logic signed [WORD_W-1:0] pos_reg, vel_reg, acc_reg, u_reg;
    // Intermediate terms
    logic signed [WORD_W-1:0] w2_reg, tmp_reg, drv_reg, damp_reg, spr_reg;
    // Multiplier
    logic signed [WORD_W:0]   mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next, prod_reg, prod_shr;
    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [WORD_W-1:0] prod_sat;
    // Output register
    logic                     out_valid_reg;
    logic        [WORD_W-1:0] out_data_reg;

    logic        [WORD_W-1:0] in_drive, in_time;

    assign in_drive = s_axis_tdata[WORD_W-1:0];
    assign in_time  = s_axis_tdata[2*WORD_W-1:WORD_W];

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            OP_VEL:    begin mul_a = {1'b0, dt_reg};           mul_b = acc_reg; end
            OP_POS:    begin mul_a = {1'b0, dt_reg};           mul_b = vel_reg; end
            OP_W2:     begin mul_a = {wn_reg[WORD_W-1], wn_reg};     mul_b = wn_reg;  end
            OP_KW2:    begin mul_a = {gain_reg[WORD_W-1], gain_reg}; mul_b = w2_reg;  end
            OP_DRIVE:  begin mul_a = {tmp_reg[WORD_W-1], tmp_reg};   mul_b = u_reg;   end
            OP_ZW:     begin mul_a = {zeta_reg[WORD_W-1], zeta_reg}; mul_b = wn_reg;  end
            OP_DAMP:   begin mul_a = {tmp_reg[WORD_W-1], tmp_reg};   mul_b = vel_reg; end
            OP_SPRING: begin mul_a = {w2_reg[WORD_W-1], w2_reg};     mul_b = pos_reg; end
            default:   begin mul_a = '0;                       mul_b = '0;      end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Floor shift and saturate the registered product
    assign prod_shr = prod_reg >>> FRAC_BITS;
    assign prod_ext = {{(SUM_W-PROD_W){prod_shr[PROD_W-1]}}, prod_shr};
    assign prod_sat = sat_word(prod_ext);

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Configuration, input capture and write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= ONE_Q;
            zeta_reg      <= ONE_Q;
            wn_reg        <= ONE_Q;
            y0_reg        <= '0;
            first_reg     <= 1'b1;
            last_time_reg <= '0;
            dt_reg        <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            acc_reg       <= '0;
            u_reg         <= '0;
            w2_reg        <= '0;
            tmp_reg       <= '0;
            drv_reg       <= '0;
            damp_reg      <= '0;
            spr_reg       <= '0;
        end
        else
        begin
            // Take a request
            if (cmd.accept)
            begin
                if (s_axis_tuser == REQ_DRIVE)
                begin
                    u_reg <= in_drive;
                end
                else if (first_reg)
                begin
                    first_reg     <= 1'b0;
                    last_time_reg <= in_time;
                    pos_reg       <= y0_reg;
                    vel_reg       <= '0;
                end
                else
                begin
                    dt_reg        <= in_time - last_time_reg;
                    last_time_reg <= in_time;
                end
            end

            // Write back the finished operation
            case (cmd.wb_op)
                OP_VEL:    vel_reg  <= sat_word(ext_word(vel_reg) + prod_ext);
                OP_POS:    pos_reg  <= sat_word(ext_word(pos_reg) + prod_ext);
                OP_W2:     w2_reg   <= prod_sat;
                OP_KW2:    tmp_reg  <= prod_sat;
                OP_DRIVE:  drv_reg  <= prod_sat;
                OP_ZW:     tmp_reg  <= prod_sat;
                OP_DAMP:   damp_reg <= sat_word(ext_word(prod_sat) <<< 1);
                OP_SPRING: spr_reg  <= prod_sat;
                OP_ACC:    acc_reg  <= sat_word(ext_word(drv_reg) - ext_word(damp_reg)
                                                - ext_word(spr_reg));
                default:   ;
            endcase

            // Any write to a known register restarts the simulation on the next time request
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN:     begin gain_reg <= cfg_data; first_reg <= 1'b1; end
                    REG_DAMPING:  begin zeta_reg <= cfg_data; first_reg <= 1'b1; end
                    REG_NAT_FREQ: begin wn_reg   <= cfg_data; first_reg <= 1'b1; end
                    REG_INIT_OUT: begin y0_reg   <= cfg_data; first_reg <= 1'b1; end
                    default:      ;
                endcase
            end
        end
    end

    // Output register: load y, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= pos_reg;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign stat.first_step = first_reg;
    assign stat.out_free   = !out_valid_reg || m_axis_tready;

endmodule

`default_nettype wire

// File: sv/second_order_system_step.sv
// A drive request is stored and gives no result. A time request gives y on m_axis after
// eight (six on a restart step) passes through the one shared 33x32 multiplier, then the
// combine and the load into the output register, which waits while that register is full.
// A new time request is taken only once the last result is loaded; one drive request per cycle while idle.
// Reset (rst_n low, asynchronous): registers return to k = zeta = wn = 1.0, y0 = 0,
// state cleared, restart pending, output empty.
`default_nettype none

module second_order_system_step
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [sos_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sos_pkg::WORD_W-1:0]    cfg_data,
    // Request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [2*sos_pkg::WORD_W-1:0]  s_axis_tdata,  // [31:0] drive_value, [63:32] time_value
    input  wire logic                          s_axis_tuser,  // [0] req_type
    // Result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [sos_pkg::WORD_W-1:0]         m_axis_tdata   // [31:0] output_value
);
    import sos_pkg::*;

    sos_cmd_t  cmd;
    sos_stat_t stat;

    sos_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    sos_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire

// File: sv/sos_checker.sv
// Port-level checks for the second-order system stepper, bound to the top level.
`default_nettype none

module sos_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [sos_pkg::WORD_W-1:0]    m_axis_tdata
);
    import sos_pkg::*;

    logic s_req;
    assign s_req = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A time request keeps the block busy after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_req && (s_axis_tuser == REQ_TIME) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("block ready too soon after a time request");

    // A drive request never brings a new result by itself
    assert property (@(posedge clk) disable iff (!rst_n)
        s_req && (s_axis_tuser == REQ_DRIVE) |=> !$rose(m_axis_tvalid))
        else $error("result appeared after a drive request");

    // A drive request frees the block again at once
    assert property (@(posedge clk) disable iff (!rst_n)
        s_req && (s_axis_tuser == REQ_DRIVE) |=> s_axis_tready)
        else $error("block busy after a drive request");

endmodule

bind second_order_system_step sos_checker u_sos_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/second_order_system_step_test.sv
// Self-checking bench for the second-order system stepper: random and directed requests.
`timescale 1ns / 100ps

module second_order_system_step_test;

    localparam int STALL_LIMIT = 20000;

    // Expected outputs of the stepper, kept by a Q16.16 semi-implicit Euler predictor
    class trajectory_board;
        localparam int FRAC = 16;

        longint    gain_q;
        longint    damping_q;
        longint    freq_q;
        longint    start_q;
        bit        restart_due;
        bit [31:0] last_tick;
        longint    pos_q;
        longint    vel_q;
        longint    acc_q;
        longint    drive_q;
        bit [31:0] expected_outputs[$];
        int        errors;

        function new();
            gain_q      = 64'sd65536;
            damping_q   = 64'sd65536;
            freq_q      = 64'sd65536;
            start_q     = 0;
            restart_due = 1'b1;
            last_tick   = '0;
            pos_q       = 0;
            vel_q       = 0;
            acc_q       = 0;
            drive_q     = 0;
            errors      = 0;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Product rounded toward minus infinity, then saturated
        function longint qmul(longint a, longint b);
            return clamp((a * b) >>> FRAC);
        endfunction

        function void update_accel();
            longint w2;
            longint drive_term;
            longint damp_term;
            longint spring_term;
            w2          = qmul(freq_q, freq_q);
            drive_term  = qmul(qmul(gain_q, w2), drive_q);
            damp_term   = clamp(2 * qmul(qmul(damping_q, freq_q), vel_q));
            spring_term = qmul(w2, pos_q);
            acc_q       = clamp(drive_term - damp_term - spring_term);
        endfunction

        // Any write to a known register restarts the simulation
        function void write_reg(bit [sos_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
            longint v;
            v = longint'($signed(val));
            case (idx)
                sos_pkg::REG_GAIN:     gain_q    = v;
                sos_pkg::REG_DAMPING:  damping_q = v;
                sos_pkg::REG_NAT_FREQ: freq_q    = v;
                sos_pkg::REG_INIT_OUT: start_q   = v;
                default:               return;
            endcase
            restart_due = 1'b1;
        endfunction

        // Note an accepted request and queue its output, if any
        function void note_request(bit kind, bit [31:0] drive_val, bit [31:0] tick);
            bit [31:0] span;
            longint    dt;
            if (kind == sos_pkg::REQ_DRIVE)
            begin
                drive_q = longint'($signed(drive_val));
                return;
            end
            if (restart_due)
            begin
                restart_due = 1'b0;
                last_tick   = tick;
                pos_q       = start_q;
                vel_q       = 0;
            end
            else
            begin
                span      = tick - last_tick;
                dt        = span;
                last_tick = tick;
                vel_q     = clamp(vel_q + ((dt * acc_q) >>> FRAC));
                pos_q     = clamp(pos_q + ((dt * vel_q) >>> FRAC));
            end
            update_accel();
            expected_outputs.push_back(pos_q[31:0]);
        endfunction

        function int pending_count();
            return expected_outputs.size();
        endfunction

        task report(string what);
            $display("%0t: output_value mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [31:0] got);
            bit [31:0] want;
            if (expected_outputs.size() == 0)
            begin
                report($sformatf("result %h with no request pending", got));
                return;
            end
            want = expected_outputs.pop_front();
            if (got !== want)
                report($sformatf("got %h, expected %h", got, want));
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [sos_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [sos_pkg::WORD_W-1:0]        cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [2*sos_pkg::WORD_W-1:0]      s_axis_tdata = '0;   // [31:0] drive_value, [63:32] time_value
    logic                              s_axis_tuser = 1'b0; // [0] req_type
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [sos_pkg::WORD_W-1:0]        m_axis_tdata;        // [31:0] output_value

    trajectory_board board = new();
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        stall_cycles = 0;
    int        items_sent = 0;
    bit [31:0] time_now = '0;

    second_order_system_step i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Check results, stall the result side at random, count cycles with no transfer
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Give up when the block stops moving
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("second_order_system_step_test failed");
        $finish;
    end

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(bit kind, bit [31:0] drive_val, bit [31:0] tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {tick, drive_val};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        board.note_request(kind, drive_val, tick);
        items_sent++;
    endtask

    task automatic send_time(bit [31:0] tick);
        send_request(sos_pkg::REQ_TIME, $urandom, tick);
        time_now = tick;
    endtask

    task automatic send_drive(bit [31:0] drive_val);
        send_request(sos_pkg::REQ_DRIVE, drive_val, $urandom);
    endtask

    // Drop valid, drain every result, then let a late drive request land
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic cfg_write(bit [sos_pkg::CFG_IDX_W-1:0] idx, bit [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic load_settings(bit [31:0] k, bit [31:0] zeta, bit [31:0] wn, bit [31:0] y0);
        settle();
        cfg_write(sos_pkg::REG_GAIN, k);
        cfg_write(sos_pkg::REG_DAMPING, zeta);
        cfg_write(sos_pkg::REG_NAT_FREQ, wn);
        cfg_write(sos_pkg::REG_INIT_OUT, y0);
        cfg_we <= 1'b0;
    endtask

    function automatic bit [31:0] extreme_word();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hffff_0000;
            default: return $urandom;
        endcase
    endfunction

    // Signed Q16.16 value spread over +/- span
    function automatic bit [31:0] spread_word(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // One stretch of stimulus: mostly a drive followed by a few time steps
    task automatic run_segment(bit wild);
        int roll;
        int steps;
        int reg_pick;
        bit kind;
        bit [31:0] tick;
        roll = $urandom_range(99);
        if (roll < 15)
        begin
            // raw noise over every bit of both fields
            kind = 1'($urandom_range(1));
            tick = $urandom;
            send_request(kind, $urandom, tick);
            if (kind == sos_pkg::REQ_TIME)
                time_now = tick;
        end
        else if (roll < 19)
        begin
            // restart mid-stream, or write an unknown register that does not restart
            settle();
            reg_pick = $urandom_range(7);
            cfg_write(reg_pick[sos_pkg::CFG_IDX_W-1:0],
                      wild ? extreme_word() : spread_word(4 * 65536));
            cfg_we <= 1'b0;
        end
        else if (roll < 23)
        begin
            // time going backwards
            send_time(time_now - $urandom_range(1, 65536));
        end
        else
        begin
            send_drive(wild ? extreme_word() : spread_word(4 * 65536));
            steps = $urandom_range(1, 6);
            repeat (steps)
                send_time(time_now + $urandom_range(1, 6554));
        end
    endtask

    initial
    begin
        int base;
        bit wild;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 61;

        // Reset settings: start, full-scale drives, wrapped and backward times
        send_time(32'h0001_0000);
        send_drive(32'h7fff_ffff);
        send_time(32'h0001_1000);
        send_time(32'h0001_2000);
        send_drive(32'h8000_0000);
        send_time(32'h0001_4000);
        send_drive(32'h0000_0000);
        send_time(32'h0001_0000);
        send_time(32'hffff_ffff);
        send_time(32'h0000_0000);

        // Unknown registers change nothing and do not restart
        settle();
        for (int idx = sos_pkg::REG_INIT_OUT + 1; idx < (1 << sos_pkg::CFG_IDX_W); idx++)
            cfg_write(idx[sos_pkg::CFG_IDX_W-1:0], 32'hffff_ffff);
        cfg_we <= 1'b0;
        send_time(32'h0000_0100);

        // Extreme settings drive every product and sum into saturation
        load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_drive(32'h7fff_ffff);
        send_time(32'hffff_0000);
        send_time(32'h0000_0000);
        send_time(32'h8000_0000);
        load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_drive(32'h8000_0000);
        send_time(32'h0000_0005);
        send_time(32'h7fff_ffff);
        send_time(32'hffff_ffff);
        load_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_time(32'h0000_0000);
        send_drive(32'h1234_5678);
        send_time(32'h0001_0000);

        // Random part: three idling profiles, fresh settings per chunk
        base = items_sent;
        for (int chunk = 0; chunk < 9; chunk++)
        begin
            if (chunk == 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 38;
            end
            else if (chunk == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wild = (chunk % 3 == 2);
            if (wild)
                load_settings(extreme_word(), extreme_word(), extreme_word(), extreme_word());
            else
                load_settings(spread_word(2 * 65536), $urandom_range(0, 98304),
                              $urandom_range(16384, 4 * 65536), spread_word(4 * 65536));
            while (items_sent < base + (chunk + 1) * 200)
                run_segment(wild);
        end

        // Drain and let any stray result show up
        s_axis_tvalid <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (board.errors == 0)
            $display("second_order_system_step_test passed");
        else
            $display("second_order_system_step_test failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/sos_pkg.sv
sv/sos_ctrl.sv
sv/sos_datapath.sv
sv/second_order_system_step.sv
sv/sos_checker.sv
bench/second_order_system_step_test.sv
